/* hdl/port_pair_bitmap_allocator_unit_assert.svh */
// Assertion macros for the port pair bitmap allocator.
// Used by the checker bound to the top level; expects clk and rst_n in scope.
`ifndef PORT_PAIR_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define PORT_PAIR_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PPBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PPBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ppba_pkg.sv */
// Shared types, constants and helper functions of the port pair bitmap allocator.
// No dependencies; compiled first.
`default_nettype none

package ppba_pkg;

  localparam int WORD_W        = 32;
  localparam int BIT_W         = $clog2(WORD_W);
  localparam int MAX_PORTS_DEF = 16384;
  localparam int PORT_W        = 16;
  localparam int COUNT_W       = 15;

  localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
  localparam logic [PORT_W-1:0]  RANGE_LOW_RST  = 16'd20000;
  localparam logic [PORT_W-1:0]  RANGE_HIGH_RST = 16'd30000;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    ACT_INIT     = 3'd0,
    ACT_RESERVE  = 3'd1,
    ACT_GET_ONE  = 3'd2,
    ACT_PUT_ONE  = 3'd3,
    ACT_GET_PAIR = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OUT_OF_PORTS  = 2'd1,
    ST_OUT_OF_RANGE  = 2'd2,
    ST_NOT_ALLOCATED = 2'd3
  } status_t;

  typedef enum logic {
    REG_RANGE_LOW  = 1'b0,
    REG_RANGE_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_RMW,
    S_SCAN,
    S_WR2
  } state_t;

  // Where the word under scan sits in the revolution.
  typedef struct packed {
    logic             start_word;
    logic             second_pass;
    logic [BIT_W-1:0] start_bit;
    logic             last_word;
    logic [BIT_W-1:0] last_bit;
    logic             base_odd;
  } scan_ctl_t;

  typedef struct packed {
    logic             one_hit;
    logic [BIT_W-1:0] one_bit;
    logic             pair_hit;
    logic [BIT_W-1:0] pair_bit;
    logic             carry_hit;   // even port in top bit, partner in next word
  } scan_res_t;

  // Lowest set bit: {found, index}.
  function automatic logic [BIT_W:0] first_set(word_t v);
    logic [BIT_W:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, BIT_W'(i)};
    end
    return r;
  endfunction

  // Bits whose offset maps to an even port number.
  function automatic word_t even_mask(logic base_odd);
    word_t m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = (i[0] == base_odd);
    end
    return m;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_add(logic [COUNT_W-1:0] a, logic [1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + (COUNT_W+1)'(b);
    return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/ppba_word_scan.sv */
// Search of one bitmap word for a free port and for a free even/odd pair.
// Depends on ppba_pkg.
`default_nettype none

module ppba_word_scan (
  input  ppba_pkg::word_t     data,
  input  ppba_pkg::scan_ctl_t ctl,
  output ppba_pkg::scan_res_t res
);
  import ppba_pkg::*;

  word_t            ones, free_w, lo_m, hi_m, hip_m, even_m, pair_free;
  logic [BIT_W:0]   one_ff, pair_ff;

  always_comb begin
    ones   = '1;
    free_w = ~data;
    even_m = even_mask(ctl.base_odd);

    // first pass: offsets at or after start; second pass: offsets before it
    if (ctl.start_word) begin
      lo_m = ctl.second_pass ? ~(ones << ctl.start_bit) : (ones << ctl.start_bit);
    end else begin
      lo_m = ones;
    end

    hi_m  = ctl.last_word ? (ones >> (BIT_W'(WORD_W - 1) - ctl.last_bit)) : ones;
    // pair partner must stay inside the range
    hip_m = ctl.last_word ? (hi_m >> 1) : ones;

    pair_free = free_w & (free_w >> 1);

    one_ff  = first_set(free_w & lo_m & hi_m);
    pair_ff = first_set(pair_free & even_m & lo_m & hip_m);

    res.one_hit   = one_ff[BIT_W];
    res.one_bit   = one_ff[BIT_W-1:0];
    res.pair_hit  = pair_ff[BIT_W];
    res.pair_bit  = pair_ff[BIT_W-1:0];
    res.carry_hit = free_w[WORD_W-1] & even_m[WORD_W-1] & lo_m[WORD_W-1] & ~ctl.last_word;
  end

endmodule

`default_nettype wire

/* hdl/port_pair_bitmap_allocator_unit.sv */
// Port pair bitmap allocator: next-fit allocator of port numbers, single or even/odd pairs.
// Depends on ppba_pkg and ppba_word_scan.
//
// Usage:
//  - Command channel: an item (in_action, in_port) transfers on a rising edge with start
//    high and busy low. busy stays high until the result strobe; one item at a time.
//  - Result channel: out_valid pulses for one cycle with out_status, out_port_low and
//    out_port_high. The receiver cannot stall; every result transfers on that edge.
//  - Config channel: cfg_valid/cfg_ready with cfg_index (0 range_low, 1 range_high) and
//    cfg_data. cfg_ready is always high; write only while busy is low.
//  - The map is one bit per port offset, kept in a single-port-write RAM of 32-bit
//    words (MAX_PORTS/32 words); each step reads one word and writes it back when it changes.
// Steps from the accepting edge to the result strobe:
//  - range error, full check failed, unknown action: answered from S_DECIDE.
//  - reserve / put: S_DECIDE reads the word, S_RMW modifies and writes it.
//  - get one / get pair: S_DECIDE, then S_SCAN for each word visited, up to one revolution
//    (at most MAX_PORTS/32 + 1 words, the start word twice); a pair that straddles
//    two words adds the S_WR2 write of its low word.
//  - init: S_DECIDE, then the clearing pass over all MAX_PORTS/32 words (512 at default).
// Typical gets find space within a few words.
// Reset: the same clearing pass runs after reset with busy high; no result is given.

`default_nettype none

module port_pair_bitmap_allocator_unit #(
  parameter int MAX_PORTS = ppba_pkg::MAX_PORTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_action,
  input  logic [ppba_pkg::PORT_W-1:0]   in_port,
  // result channel
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [ppba_pkg::PORT_W-1:0]   out_port_low,
  output logic [ppba_pkg::PORT_W-1:0]   out_port_high,
  // config channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [ppba_pkg::PORT_W-1:0]   cfg_data
);
  import ppba_pkg::*;

  localparam int WORDS = (MAX_PORTS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int OW    = AW + BIT_W;          // port offset
  localparam int CW    = OW + 1;              // port count
  localparam int RW    = PORT_W + 1;          // range arithmetic
  localparam logic [RW-1:0] MAXP = RW'(MAX_PORTS);

  // ---------------------------------------------------------------- state
  state_t              state_r, state_nxt;
  logic [PORT_W-1:0]   rl_r, rl_nxt, rh_r, rh_nxt;
  logic [PORT_W-1:0]   np_r, np_nxt;           // rotating pointer
  logic [COUNT_W-1:0]  used_r, used_nxt, rsv_r, rsv_nxt;
  logic                init_r, init_nxt;       // clearing pass belongs to an init item
  logic [AW-1:0]       clr_r, clr_nxt;
  logic                out_valid_r, out_valid_nxt;

  // item context (no reset needed)
  action_t             act_r, act_nxt;
  logic [PORT_W-1:0]   port_r, port_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [OW-1:0]       off_r, off_nxt;         // offset of reserved / freed port
  logic [OW-1:0]       s_r, s_nxt;             // scan start offset
  logic [OW-1:0]       last_r, last_nxt;       // last offset in range
  logic [AW-1:0]       w_r, w_nxt;             // word under scan
  logic                pass_r, pass_nxt;
  logic                carry_r, carry_nxt;
  logic [AW-1:0]       carry_w_r, carry_w_nxt;
  word_t               carry_d_r, carry_d_nxt;
  status_t             status_r, status_nxt;
  logic [PORT_W-1:0]   plo_r, plo_nxt, phi_r, phi_nxt;
  logic                res_ld;

  // ---------------------------------------------------------------- bitmap RAM
  word_t               map_mem [WORDS];
  word_t               rd_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_wa, mem_ra;
  word_t               mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= map_mem[mem_ra];
  end

  // ---------------------------------------------------------------- word search
  scan_ctl_t           scan_ctl;
  scan_res_t           scan_res;

  assign scan_ctl.start_word  = (w_r == s_r[OW-1:BIT_W]);
  assign scan_ctl.second_pass = pass_r;
  assign scan_ctl.start_bit   = s_r[BIT_W-1:0];
  assign scan_ctl.last_word   = (w_r == last_r[OW-1:BIT_W]);
  assign scan_ctl.last_bit    = last_r[BIT_W-1:0];
  assign scan_ctl.base_odd    = rl_r[0];

  ppba_word_scan u_scan (
    .data (rd_q),
    .ctl  (scan_ctl),
    .res  (scan_res)
  );

  // ---------------------------------------------------------------- range math
  logic [RW-1:0]       cnt_raw, cnt_lim, cnt_w, sum_w;
  logic                port_ok, np_ok, one_full, pair_full;
  logic [OW-1:0]       port_off, start_off, cnt_last;

  always_comb begin
    cnt_raw = (rh_r < rl_r) ? '0 : (RW'(rh_r) - RW'(rl_r) + RW'(1));
    cnt_lim = (cnt_raw > MAXP) ? MAXP : cnt_raw;

    cnt_w     = RW'(cnt_r);
    port_ok   = (cnt_r != '0) && (port_r >= rl_r) && (RW'(port_r - rl_r) < cnt_w);
    np_ok     = (cnt_r != '0) && (np_r >= rl_r) && (RW'(np_r - rl_r) < cnt_w);
    port_off  = OW'(port_r - rl_r);
    start_off = np_ok ? OW'(np_r - rl_r) : '0;
    cnt_last  = OW'(cnt_r - CW'(1));
    sum_w     = RW'(used_r) + RW'(rsv_r);
    one_full  = (sum_w >= cnt_w);
    pair_full = (cnt_r == '0) || ((sum_w + RW'(3)) > cnt_w);
  end

  // ---------------------------------------------------------------- control
  logic                bit_set, carry_take;
  logic [OW-1:0]       one_off, pair_off;
  word_t               bit_oh;

  always_comb begin
    bit_set    = rd_q[off_r[BIT_W-1:0]];
    bit_oh     = word_t'(1) << off_r[BIT_W-1:0];
    carry_take = carry_r && !rd_q[0];
    one_off    = {w_r, scan_res.one_bit};
    pair_off   = carry_take ? {carry_w_r, BIT_W'(WORD_W - 1)} : {w_r, scan_res.pair_bit};
  end

  always_comb begin
    state_nxt     = state_r;
    rl_nxt        = rl_r;
    rh_nxt        = rh_r;
    np_nxt        = np_r;
    used_nxt      = used_r;
    rsv_nxt       = rsv_r;
    init_nxt      = init_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    act_nxt       = act_r;
    port_nxt      = port_r;
    cnt_nxt       = cnt_r;
    off_nxt       = off_r;
    s_nxt         = s_r;
    last_nxt      = last_r;
    w_nxt         = w_r;
    pass_nxt      = pass_r;
    carry_nxt     = carry_r;
    carry_w_nxt   = carry_w_r;
    carry_d_nxt   = carry_d_r;
    status_nxt    = ST_OK;
    plo_nxt       = '0;
    phi_nxt       = '0;
    res_ld        = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = w_r;
    mem_wd        = rd_q;
    mem_re        = 1'b0;
    mem_ra        = w_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RANGE_LOW:  rl_nxt = cfg_data;
        REG_RANGE_HIGH: rh_nxt = cfg_data;
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        if (clr_r == AW'(WORDS - 1)) begin
          state_nxt = S_IDLE;
          init_nxt  = 1'b0;
          if (init_r) begin
            res_ld        = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          act_nxt   = action_t'(in_action);
          port_nxt  = in_port;
          cnt_nxt   = CW'(cnt_lim);
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        carry_nxt = 1'b0;
        pass_nxt  = 1'b0;
        s_nxt     = start_off;
        last_nxt  = cnt_last;
        off_nxt   = port_off;
        w_nxt     = start_off[OW-1:BIT_W];
        unique case (act_r)
          ACT_INIT: begin
            used_nxt  = '0;
            rsv_nxt   = '0;
            np_nxt    = rl_r;
            clr_nxt   = '0;
            init_nxt  = 1'b1;
            state_nxt = S_CLEAR;
          end
          ACT_RESERVE, ACT_PUT_ONE: begin
            if (!port_ok) begin
              status_nxt    = ST_OUT_OF_RANGE;
              res_ld        = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              mem_re    = 1'b1;
              mem_ra    = port_off[OW-1:BIT_W];
              state_nxt = S_RMW;
            end
          end
          ACT_GET_ONE, ACT_GET_PAIR: begin
            if ((act_r == ACT_GET_ONE) ? one_full : pair_full) begin
              status_nxt    = ST_OUT_OF_PORTS;
              res_ld        = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              mem_re    = 1'b1;
              mem_ra    = start_off[OW-1:BIT_W];
              state_nxt = S_SCAN;
            end
          end
          default: begin
            // undefined action codes: plain ok, nothing changes
            res_ld        = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end

      S_RMW: begin
        mem_wa        = off_r[OW-1:BIT_W];
        res_ld        = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (act_r == ACT_RESERVE) begin
          if (!bit_set) begin
            mem_we  = 1'b1;
            mem_wd  = rd_q | bit_oh;
            rsv_nxt = sat_add(rsv_r, 2'd1);
          end
        end else begin
          if (!bit_set) begin
            status_nxt = ST_NOT_ALLOCATED;
          end else begin
            mem_we   = 1'b1;
            mem_wd   = rd_q & ~bit_oh;
            used_nxt = (used_r != '0) ? (used_r - COUNT_W'(1)) : '0;
          end
        end
      end

      S_SCAN: begin
        if ((act_r == ACT_GET_ONE) && scan_res.one_hit) begin
          mem_we        = 1'b1;
          mem_wd        = rd_q | (word_t'(1) << scan_res.one_bit);
          used_nxt      = sat_add(used_r, 2'd1);
          plo_nxt       = rl_r + PORT_W'(one_off);
          np_nxt        = ((RW'(one_off) + RW'(1)) == RW'(cnt_r)) ? rl_r
                          : (rl_r + PORT_W'(one_off) + PORT_W'(1));
          res_ld        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if ((act_r == ACT_GET_PAIR) && (carry_take || scan_res.pair_hit)) begin
          mem_we   = 1'b1;
          // straddling pair: low word written back in the next cycle
          mem_wd   = carry_take ? (rd_q | word_t'(1))
                     : (rd_q | (word_t'(3) << scan_res.pair_bit));
          used_nxt = sat_add(used_r, 2'd2);
          plo_nxt  = rl_r + PORT_W'(pair_off);
          phi_nxt  = rl_r + PORT_W'(pair_off) + PORT_W'(1);
          np_nxt   = ((RW'(pair_off) + RW'(2)) == RW'(cnt_r)) ? rl_r
                     : (rl_r + PORT_W'(pair_off) + PORT_W'(2));
          res_ld   = 1'b1;
          if (carry_take) begin
            state_nxt = S_WR2;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          carry_nxt   = scan_res.carry_hit;
          carry_w_nxt = w_r;
          carry_d_nxt = rd_q;
          priority if (!pass_r && scan_ctl.last_word) begin
            // wrap to the bottom of the range
            pass_nxt = 1'b1;
            w_nxt    = '0;
            mem_re   = 1'b1;
            mem_ra   = '0;
          end else if (pass_r && scan_ctl.start_word) begin
            // full revolution without a hit
            status_nxt    = ST_OUT_OF_PORTS;
            res_ld        = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            w_nxt  = w_r + AW'(1);
            mem_re = 1'b1;
            mem_ra = w_r + AW'(1);
          end
        end
      end

      S_WR2: begin
        mem_we        = 1'b1;
        mem_wa        = carry_w_r;
        mem_wd        = carry_d_r | (word_t'(1) << (WORD_W - 1));
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      rl_r        <= RANGE_LOW_RST;
      rh_r        <= RANGE_HIGH_RST;
      np_r        <= RANGE_LOW_RST;
      used_r      <= '0;
      rsv_r       <= '0;
      init_r      <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rl_r        <= rl_nxt;
      rh_r        <= rh_nxt;
      np_r        <= np_nxt;
      used_r      <= used_nxt;
      rsv_r       <= rsv_nxt;
      init_r      <= init_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    port_r    <= port_nxt;
    cnt_r     <= cnt_nxt;
    off_r     <= off_nxt;
    s_r       <= s_nxt;
    last_r    <= last_nxt;
    w_r       <= w_nxt;
    pass_r    <= pass_nxt;
    carry_r   <= carry_nxt;
    carry_w_r <= carry_w_nxt;
    carry_d_r <= carry_d_nxt;
    if (res_ld) begin
      status_r <= status_nxt;
      plo_r    <= plo_nxt;
      phi_r    <= phi_nxt;
    end
  end

  // ---------------------------------------------------------------- ports
  assign busy          = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_port_low  = plo_r;
  assign out_port_high = phi_r;

endmodule

`default_nettype wire

/* hdl/ppba_port_checker.sv */
// Port-level checks of the port pair bitmap allocator, bound to the top level.
// Depends on ppba_pkg and port_pair_bitmap_allocator_unit_assert.svh.
`default_nettype none

`include "port_pair_bitmap_allocator_unit_assert.svh"

module ppba_port_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [1:0]                  out_status,
  input logic [ppba_pkg::PORT_W-1:0] out_port_low,
  input logic [ppba_pkg::PORT_W-1:0] out_port_high
);
  import ppba_pkg::*;

  // one result per item, never back to back
  `PPBA_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held")

  `PPBA_ASSERT_NEXT(a_busy_after_transfer, start && !busy, busy, "busy missing after transfer")

  // a result only ends a busy period
  `PPBA_ASSERT_NOW(a_result_after_work, out_valid, $past(busy), "result without work")

  `PPBA_ASSERT_NOW(a_fail_zero, out_valid && (out_status != ST_OK), (out_port_low == '0) && (out_port_high == '0), "ports on failed result")

  `PPBA_ASSERT_NOW(a_pair_shape, out_valid && (out_port_high != '0), (out_status == ST_OK) && !out_port_low[0] && (out_port_high == out_port_low + 16'd1), "malformed pair")

endmodule

bind port_pair_bitmap_allocator_unit ppba_port_checker u_ppba_port_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_port_low  (out_port_low),
  .out_port_high (out_port_high)
);

`default_nettype wire
